// ----- design/dle_stx_frame_encoder_defines.svh -----
// Assertion macros shared by the frame encoder modules.
`ifndef DLE_STX_FRAME_ENCODER_DEFINES_SVH
`define DLE_STX_FRAME_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSFE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/dsfe_pkg.sv -----
// Package with the line symbols, the command type and the emit step codes.
package dsfe_pkg;

    // Line control symbols.
    localparam logic [7:0] SYM_DLE = 8'h10;
    localparam logic [7:0] SYM_STX = 8'h02;
    localparam logic [7:0] SYM_ETX = 8'h03;

    // One classified payload byte, as the front hands it to the back.
    typedef struct packed {
        logic [7:0] data;   // payload byte
        logic       hdr;    // frame opens with this byte: send DLE STX first
        logic       stuff;  // byte equals DLE: send a stuffing DLE first
        logic       last;   // byte closes the frame: send DLE ETX check after it
        logic [7:0] check;  // closing check byte, valid when last is set
    } t_cmd;

    // One-hot steps of the back-end sequencer, in line order.
    typedef enum logic [6:0] {
        ST_HDR_DLE = 7'b0000001,
        ST_HDR_STX = 7'b0000010,
        ST_STUFF   = 7'b0000100,
        ST_DATA    = 7'b0001000,
        ST_TRL_DLE = 7'b0010000,
        ST_TRL_ETX = 7'b0100000,
        ST_CHECK   = 7'b1000000
    } t_step;

endpackage

// ----- design/dsfe_front.sv -----
// Front end: accepts payload bytes, tracks the frame and builds commands.
module dsfe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [7:0]     i_s_tdata,
    input  logic           i_s_tlast,
    input  logic           i_full,
    output logic           o_push,
    output dsfe_pkg::t_cmd o_cmd
);
    import dsfe_pkg::*;

    logic       r_in_frame;
    logic [7:0] r_check;
    logic       n_in_frame;
    logic [7:0] n_check;
    logic [7:0] w_base;
    logic [7:0] w_acc;

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    // A new frame starts its check from zero.
    assign w_base = r_in_frame ? r_check : 8'h00;
    assign w_acc  = w_base ^ i_s_tdata;

    // Classify the byte into a command for the back end.
    always_comb begin
        o_cmd.data  = i_s_tdata;
        o_cmd.hdr   = !r_in_frame;
        o_cmd.stuff = (i_s_tdata == SYM_DLE);
        o_cmd.last  = i_s_tlast;
        o_cmd.check = w_acc ^ SYM_ETX;
    end

    // Frame state advances on every accepted transaction.
    always_comb begin
        n_in_frame = r_in_frame;
        n_check    = r_check;
        if (o_push) begin
            n_in_frame = !i_s_tlast;
            n_check    = i_s_tlast ? 8'h00 : w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_check    <= 8'h00;
        end else begin
            r_in_frame <= n_in_frame;
            r_check    <= n_check;
        end
    end

endmodule

// ----- design/dsfe_queue.sv -----
// Short command queue between the front and back ends.
`include "dle_stx_frame_encoder_defines.svh"
module dsfe_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dsfe_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dsfe_pkg::t_cmd o_cmd
);
    import dsfe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wptr;
    logic [AW-1:0] n_rptr;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    // Pointers wrap at the queue depth.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    `DSFE_ASSERT_SAME(a_no_overflow, i_push, !o_full || i_pop, "push into a full queue")
    `DSFE_ASSERT_SAME(a_no_underflow, i_pop, o_valid, "pop from an empty queue")
    `DSFE_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count lost a push")

endmodule

// ----- design/dsfe_back.sv -----
// Back end: steps through each command and sends the line bytes.
`include "dle_stx_frame_encoder_defines.svh"
module dsfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  dsfe_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,
    output logic           o_m_tlast,
    output logic           o_m_tuser
);
    import dsfe_pkg::*;

    logic       r_busy;
    t_cmd       r_cmd;
    t_step      r_step;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;
    logic       r_oend;
    logic       n_busy;
    t_step      n_step;
    logic       w_emit;
    logic       w_done;
    logic       w_load;
    logic [7:0] w_byte;
    t_step      w_first;
    t_step      w_after;

    // While a command is loaded, a byte leaves the sequencer whenever the output register is free.
    assign w_emit  = r_busy && (!r_ovalid || i_m_tready);
    assign w_done  = (r_step == ST_CHECK) || ((r_step == ST_DATA) && !r_cmd.last);
    assign w_load  = i_q_valid && (!r_busy || (w_emit && w_done));
    assign o_q_pop = w_load;

    // Entry step for a fresh command.
    always_comb begin
        if (i_q_cmd.hdr) begin
            w_first = ST_HDR_DLE;
        end else if (i_q_cmd.stuff) begin
            w_first = ST_STUFF;
        end else begin
            w_first = ST_DATA;
        end
    end

    // Following step within the current command.
    always_comb begin
        case (r_step)
            ST_HDR_DLE: w_after = ST_HDR_STX;
            ST_HDR_STX: w_after = r_cmd.stuff ? ST_STUFF : ST_DATA;
            ST_STUFF:   w_after = ST_DATA;
            ST_DATA:    w_after = ST_TRL_DLE;
            ST_TRL_DLE: w_after = ST_TRL_ETX;
            ST_TRL_ETX: w_after = ST_CHECK;
            ST_CHECK:   w_after = ST_CHECK;
            default:    w_after = ST_DATA;
        endcase
    end

    // Byte sent at each step.
    always_comb begin
        case (r_step)
            ST_HDR_DLE: w_byte = SYM_DLE;
            ST_HDR_STX: w_byte = SYM_STX;
            ST_STUFF:   w_byte = SYM_DLE;
            ST_DATA:    w_byte = r_cmd.data;
            ST_TRL_DLE: w_byte = SYM_DLE;
            ST_TRL_ETX: w_byte = SYM_ETX;
            ST_CHECK:   w_byte = r_cmd.check;
            default:    w_byte = SYM_DLE;
        endcase
    end

    // Sequencer control.
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (w_load) begin
            n_busy = 1'b1;
            n_step = w_first;
        end else if (w_emit) begin
            if (w_done) begin
                n_busy = 1'b0;
            end else begin
                n_step = w_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= ST_DATA;
            r_ovalid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            if (!r_ovalid || i_m_tready) begin
                r_ovalid <= w_emit;
            end
        end
    end

    // Command and output payload registers.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_q_cmd;
        end
        if (w_emit) begin
            r_obyte <= w_byte;
            r_olast <= w_done;
            r_oend  <= (r_step == ST_CHECK);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_obyte;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_oend;

    `DSFE_ASSERT_SAME(a_step_onehot, r_busy, $onehot(r_step), "sequencer step not one-hot")
    `DSFE_ASSERT_SAME(a_end_is_last, r_ovalid && r_oend, r_olast, "check byte not marked last")
    `DSFE_ASSERT_NEXT(a_load_busy, w_load, r_busy, "loaded command left sequencer idle")

endmodule

// ----- design/dle_stx_frame_encoder.sv -----
// Top level of the DLE/STX/ETX frame encoder with XOR check byte.
//
// Usage: payload bytes enter on the s_axis channel, one per transaction,
// tdata carrying the byte and tlast marking the final byte of a frame.
// Encoded line bytes leave on the m_axis channel, one per transaction:
// tdata is the line byte, tlast marks the last line byte caused by one
// input byte and tuser marks the closing check byte of a frame.
// A frame's first byte is preceded by DLE STX, a DLE byte is doubled and
// the last byte is followed by DLE ETX and the XOR check byte.
// The first line byte of an input passes through the command queue, the
// sequencer command register and the output register. The sequencer sends
// one line byte per cycle while commands wait and the receiver is ready;
// an input causes one or two line bytes in mid frame, up to seven for a one-byte frame.
// The front end accepts while the command queue (QUEUE_DEPTH entries) has
// room, so input keeps flowing while the back end works.
// Reset clears the frame state, the queue, the sequencer and the output valid.
// When the receiver holds tready low, the output transaction holds, the
// sequencer waits and the queue fills before s_axis tready drops.
module dle_stx_frame_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // last_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic       o_m_axis_tlast,   // run_last
    output logic       o_m_axis_tuser    // [0] frame_end
);
    import dsfe_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_qvalid;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;

    // Front end classifies each input byte.
    dsfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tlast  (i_s_axis_tlast),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // Queue decouples the two ends.
    dsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_cmd   (w_head_cmd)
    );

    // Back end sends the line bytes.
    dsfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_qvalid),
        .i_q_cmd    (w_head_cmd),
        .o_q_pop    (w_pop),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule

// ----- tb/sv/tb_dle_stx_frame_encoder.sv -----
// Self-checking testbench for the DLE/STX/ETX frame encoder with XOR check byte.
module tb_dle_stx_frame_encoder;

    import dsfe_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 450;

    // One payload byte waiting to be offered on the slave side.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_payload;

    // One encoded line byte as it should leave the master side.
    typedef struct {
        logic [7:0] line_byte;
        logic       run_last;
        logic       frame_end;
    } t_line;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;    // [7:0] data_byte
    logic       i_s_axis_tlast;    // last_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;    // [7:0] out_byte
    logic       o_m_axis_tlast;    // run_last
    logic       o_m_axis_tuser;    // [0] frame_end

    t_payload   payload_q[$];
    t_line      line_q[$];
    int         errors     = 0;
    int         cycles     = 0;
    bit         took       = 1'b0;
    bit         quiet      = 1'b0;
    int         quiet_left = 0;
    int         src_gap    = 0;
    int         snk_gap    = 0;

    // Predictor state: frame open flag and running XOR of the payload.
    logic       frame_open = 1'b0;
    logic [7:0] frame_xor  = 8'h00;

    dle_stx_frame_encoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock with a period of ten units.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Idle lengths: mostly none or short, now and then long, none in quiet stretches.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s, got 0x%0h, expected 0x%0h", cycles, what, got, want);
        errors = errors + 1;
    endtask

    // Works out the line bytes that one accepted payload byte causes.
    task automatic encode_payload_byte(input logic [7:0] b, input logic lst);
        logic [7:0] seq [0:6];
        logic       chk [0:6];
        int         n;
        t_line      item;
        n = 0;
        // A byte arriving outside a frame opens one with DLE STX.
        if (!frame_open) begin
            seq[0]     = SYM_DLE;
            chk[0]     = 1'b0;
            seq[1]     = SYM_STX;
            chk[1]     = 1'b0;
            n          = 2;
            frame_open = 1'b1;
            frame_xor  = 8'h00;
        end
        // A payload DLE is preceded by a stuffing DLE outside the check.
        if (b == SYM_DLE) begin
            seq[n] = SYM_DLE;
            chk[n] = 1'b0;
            n      = n + 1;
        end
        seq[n]    = b;
        chk[n]    = 1'b0;
        n         = n + 1;
        frame_xor = frame_xor ^ b;
        // The closing byte is followed by DLE ETX and the check, which covers ETX.
        if (lst) begin
            seq[n]     = SYM_DLE;
            chk[n]     = 1'b0;
            seq[n + 1] = SYM_ETX;
            chk[n + 1] = 1'b0;
            seq[n + 2] = frame_xor ^ SYM_ETX;
            chk[n + 2] = 1'b1;
            n          = n + 3;
            frame_open = 1'b0;
            frame_xor  = 8'h00;
        end
        for (int i = 0; i < n; i++) begin
            item.line_byte = seq[i];
            item.run_last  = (i == n - 1);
            item.frame_end = chk[i];
            line_q.push_back(item);
        end
    endtask

    task automatic push_payload(input logic [7:0] b, input logic lst);
        t_payload p;
        p.data = b;
        p.last = lst;
        payload_q.push_back(p);
    endtask

    // Random frame: short ones are common, DLE and the control symbols frequent.
    task automatic push_random_frame(output int len);
        int r;
        int p;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            len = $urandom_range(1, 4);
        end else if (r < 90) begin
            len = $urandom_range(5, 12);
        end else begin
            len = $urandom_range(13, 40);
        end
        for (int i = 0; i < len; i++) begin
            p = $urandom_range(0, 99);
            if (p < 20) begin
                b = SYM_DLE;
            end else if (p < 25) begin
                b = ($urandom_range(0, 1) == 1) ? SYM_STX : SYM_ETX;
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            push_payload(b, i == len - 1);
        end
    endtask

    // Cycle count, quiet stretches and the timeout.
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (quiet_left > 0) begin
            quiet_left = quiet_left - 1;
        end else begin
            quiet      = ($urandom_range(0, 3) == 0);
            quiet_left = $urandom_range(50, 300);
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("dle_stx_frame_encoder regression: fail");
            $finish;
        end
    end

    // Monitor: predicts on each input transaction and checks each output transaction.
    always @(posedge i_clk) begin
        t_line want;
        took = 1'b0;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                encode_payload_byte(i_s_axis_tdata, i_s_axis_tlast);
                took = 1'b1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (line_q.size() == 0) begin
                    report_mismatch("unexpected line byte", o_m_axis_tdata, 0);
                end else begin
                    want = line_q.pop_front();
                    if (o_m_axis_tdata !== want.line_byte)
                        report_mismatch("out_byte", o_m_axis_tdata, want.line_byte);
                    if (o_m_axis_tlast !== want.run_last)
                        report_mismatch("run_last", o_m_axis_tlast, want.run_last);
                    if (o_m_axis_tuser !== want.frame_end)
                        report_mismatch("frame_end", o_m_axis_tuser, want.frame_end);
                end
            end
        end
    end

    // Driver: offers queued payload bytes with random idle cycles between them.
    always @(negedge i_clk) begin
        if (took) begin
            payload_q.delete(0);
        end
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !took) begin
            // Hold the offered transaction until it is accepted.
        end else if (src_gap > 0) begin
            src_gap = src_gap - 1;
            i_s_axis_tvalid <= 1'b0;
        end else if (payload_q.size() > 0) begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= payload_q[0].data;
            i_s_axis_tlast  <= payload_q[0].last;
            src_gap = draw_gap();
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: stalls the master side at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap = snk_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            snk_gap = draw_gap();
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int total;
        int len;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;

        // One-byte frames: a DLE byte gives the longest run, then both extremes.
        push_payload(SYM_DLE, 1'b1);
        push_payload(8'h00, 1'b1);
        push_payload(8'hFF, 1'b1);
        // Control symbols and doubled DLE as payload inside one frame.
        push_payload(SYM_STX, 1'b0);
        push_payload(SYM_ETX, 1'b0);
        push_payload(SYM_DLE, 1'b0);
        push_payload(SYM_DLE, 1'b0);
        push_payload(8'hA5, 1'b1);
        // A frame that closes on a DLE byte.
        push_payload(8'h5A, 1'b0);
        push_payload(SYM_DLE, 1'b1);
        // Check bytes that come out as DLE and as zero.
        push_payload(8'h13, 1'b1);
        push_payload(SYM_ETX, 1'b1);
        // A longer frame over walking bit patterns.
        push_payload(8'h01, 1'b0);
        push_payload(8'h80, 1'b0);
        push_payload(8'h55, 1'b0);
        push_payload(8'hAA, 1'b0);
        push_payload(8'h7F, 1'b1);

        total = 0;
        while (total < RANDOM_ITEMS) begin
            push_random_frame(len);
            total = total + len;
        end

        // Hold reset, then release it at a falling edge.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (payload_q.size() != 0 || i_s_axis_tvalid || line_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (line_q.size() != 0)
            report_mismatch("line bytes never sent", line_q.size(), 0);

        if (errors == 0) begin
            $display("dle_stx_frame_encoder regression: pass");
        end else begin
            $display("dle_stx_frame_encoder regression: fail");
        end
        $finish;
    end

endmodule
